>>> sv/greyscale_bitplane_packer_core_assert.svh
// Assertion macros for the greyscale bit-plane packer.
// Needs clk_i and rst_ni in the including module.
`ifndef GREYSCALE_BITPLANE_PACKER_CORE_ASSERT_SVH
`define GREYSCALE_BITPLANE_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gbp assertion failed");

// Next-cycle implication, disabled during reset.
`define GBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gbp assertion failed");

`endif

>>> sv/gbp_pkg.sv
// Shared types, constants and the threshold table of the bit-plane packer.
// No dependencies.
`default_nettype none

package gbp_pkg;

  localparam int unsigned LINE_PIXELS = 128;
  localparam int unsigned FRAME_LINES = 296;

  localparam int unsigned PixW   = 8;
  localparam int unsigned LevelW = 7;
  localparam int unsigned Levels = 128;
  localparam int unsigned WordW  = 32;
  localparam int unsigned GroupW = $clog2(WordW);
  localparam int unsigned ColW   = 7;
  localparam int unsigned RowW   = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  localparam logic [ColW-1:0] LastCol = ColW'(LINE_PIXELS - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(FRAME_LINES - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PLANE_MASK = 2'd0,
    CFG_WIN_FIRST  = 2'd1,
    CFG_WIN_LAST   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] plane_mask;
    logic [RowW-1:0]   window_first_row;
    logic [RowW-1:0]   window_last_row;
  } gbp_cfg_t;

  typedef struct packed {
    logic advance;
    logic s1_valid;
  } gbp_ctrl_t;

  localparam logic [PixW-1:0] LEVEL_TABLE [Levels] = '{
      8'd0,   8'd4,   8'd9,   8'd13,  8'd17,  8'd22,  8'd26,  8'd30,
      8'd34,  8'd38,  8'd42,  8'd45,  8'd49,  8'd53,  8'd57,  8'd60,
      8'd64,  8'd67,  8'd71,  8'd74,  8'd77,  8'd81,  8'd84,  8'd87,
      8'd90,  8'd93,  8'd97,  8'd100, 8'd103, 8'd105, 8'd108, 8'd111,
      8'd114, 8'd117, 8'd119, 8'd122, 8'd125, 8'd127, 8'd130, 8'd132,
      8'd135, 8'd137, 8'd140, 8'd142, 8'd145, 8'd147, 8'd149, 8'd151,
      8'd154, 8'd156, 8'd158, 8'd160, 8'd162, 8'd164, 8'd166, 8'd168,
      8'd170, 8'd172, 8'd174, 8'd176, 8'd178, 8'd179, 8'd181, 8'd183,
      8'd185, 8'd186, 8'd188, 8'd190, 8'd191, 8'd193, 8'd195, 8'd196,
      8'd198, 8'd199, 8'd201, 8'd202, 8'd204, 8'd205, 8'd206, 8'd208,
      8'd209, 8'd211, 8'd212, 8'd213, 8'd214, 8'd216, 8'd217, 8'd218,
      8'd219, 8'd221, 8'd222, 8'd223, 8'd224, 8'd225, 8'd226, 8'd227,
      8'd228, 8'd230, 8'd231, 8'd232, 8'd233, 8'd234, 8'd235, 8'd236,
      8'd237, 8'd237, 8'd238, 8'd239, 8'd240, 8'd241, 8'd242, 8'd243,
      8'd244, 8'd245, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd249,
      8'd250, 8'd251, 8'd252, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255
  };

  // Table is nondecreasing: the index of the first entry not below pix equals the
  // number of entries below pix.
  function automatic logic [LevelW-1:0] pixel_level(input logic [PixW-1:0] pix);
    logic [LevelW-1:0] lvl;
    lvl = '0;
    for (int k = 0; k < Levels - 1; k++) begin
      if (pix > LEVEL_TABLE[k]) lvl = lvl + 1'b1;
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

>>> sv/gbp_level_rom.sv
// Synchronous pixel-to-level ROM with a registered read, held while advance_i is low.
// Depends on gbp_pkg.
`default_nettype none

module gbp_level_rom (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic                      in_valid_i,
  input  logic [gbp_pkg::PixW-1:0]  pixel_value_i,
  output logic                      s1_valid_o,
  output logic [gbp_pkg::LevelW-1:0] level_o
);
  import gbp_pkg::*;

  logic [LevelW-1:0] rom_q [2**PixW];
  logic [LevelW-1:0] level_q;
  logic              s1_valid_q;

  always_comb begin
    for (int p = 0; p < 2**PixW; p++) begin
      rom_q[p] = pixel_level(PixW'(p));
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      level_q <= rom_q[pixel_value_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance_i) begin
      s1_valid_q <= in_valid_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign level_o    = level_q;

endmodule

`default_nettype wire

>>> sv/gbp_packer.sv
// Column/row counters, plane-bit shifter and output register.
// Depends on gbp_pkg and greyscale_bitplane_packer_core_assert.svh.
`default_nettype none

module gbp_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gbp_pkg::gbp_cfg_t           cfg_i,
  input  gbp_pkg::gbp_ctrl_t          ctrl_i,
  input  logic [gbp_pkg::LevelW-1:0]  level_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [gbp_pkg::WordW-1:0]   packed_word_o,
  output logic                        frame_end_o
);
  import gbp_pkg::*;
  `include "greyscale_bitplane_packer_core_assert.svh"

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [WordW-1:0] shifter_q, shifter_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] word_q, word_d;
  logic             frame_end_q, frame_end_d;

  logic             fire, in_win, plane_bit, emit, row_end, last_word;
  logic [WordW-1:0] shift_nxt;
  logic [ColW:0]    col_plus;

  always_comb begin
    fire      = ctrl_i.s1_valid && ctrl_i.advance;
    in_win    = (row_q >= cfg_i.window_first_row) && (row_q <= cfg_i.window_last_row);
    plane_bit = in_win && ((level_i & cfg_i.plane_mask) != '0);
    shift_nxt = {shifter_q[WordW-2:0], plane_bit};
    emit      = fire && (&col_q[GroupW-1:0]);
    row_end   = (col_q == LastCol);
    col_plus  = {1'b0, col_q} + (ColW+1)'(WordW);
    last_word = (row_q == LastRow) && (col_plus >= (ColW+1)'(LINE_PIXELS));

    col_d       = col_q;
    row_d       = row_q;
    shifter_d   = shifter_q;
    out_valid_d = out_valid_q;
    word_d      = word_q;
    frame_end_d = frame_end_q;

    if (fire) begin
      if (row_end) begin
        col_d     = '0;
        shifter_d = '0;
        row_d     = (row_q == LastRow) ? '0 : row_q + 1'b1;
      end else begin
        col_d     = col_q + 1'b1;
        shifter_d = shift_nxt;
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
      word_d      = shift_nxt;
      frame_end_d = last_word;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      shifter_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      shifter_q   <= shifter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q      <= word_d;
    frame_end_q <= frame_end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = word_q;
  assign frame_end_o   = frame_end_q;

  `GBP_ASSERT_NOW(a_col_range, 1'b1, col_q <= LastCol)
  `GBP_ASSERT_NOW(a_row_range, 1'b1, row_q <= LastRow)
  `GBP_ASSERT_NEXT(a_row_end_clear, fire && row_end, (col_q == '0) && (shifter_q == '0))
  `GBP_ASSERT_NOW(a_emit_slot_free, emit, !(out_valid_q && out_stall_i))

endmodule

`default_nettype wire

>>> sv/greyscale_bitplane_packer_core.sv
// Greyscale bit-plane packer, top level.
// Depends on gbp_pkg, gbp_level_rom and gbp_packer.
//
// Usage:
//   Pixels enter on in_valid_i/in_stall_o with pixel_value_i, raster order,
//   LINE_PIXELS per row and FRAME_LINES rows per frame. Each pixel is mapped
//   to a level through a synchronous ROM, masked with plane_mask and gated by
//   the row window; the plane bits are packed MSB first.
//   A 32-bit word leaves on out_valid_o/out_stall_i with packed_word_o and
//   frame_end_o after every 32nd pixel of a row; frame_end_o marks the last
//   word of the frame. Trailing pixels of a row beyond the last full word
//   are dropped.
//   Throughput: one pixel per cycle, sustained while the output is not stalled.
//   Pipeline: two register stages (ROM read, output register); the last pixel of
//   a word passes the ROM register before the word enters the output register.
//   Stall: while a word sits in the output register and out_stall_i is high,
//   the ROM stage and counters hold and in_stall_o is raised.
//   Reset clears counters, shifter and valids; registers take plane_mask 64,
//   window 0..295. Write configuration only while the block is idle.
`default_nettype none

module greyscale_bitplane_packer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gbp_pkg::PixW-1:0]      pixel_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gbp_pkg::WordW-1:0]     packed_word_o,
  output logic                          frame_end_o,
  input  logic                          cfg_we_i,
  input  logic [gbp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gbp_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gbp_pkg::*;

  gbp_cfg_t          cfg_q;
  gbp_ctrl_t         ctrl;
  logic [LevelW-1:0] level;
  logic              s1_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.plane_mask       <= LevelW'(64);
      cfg_q.window_first_row <= '0;
      cfg_q.window_last_row  <= RowW'(295);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PLANE_MASK: cfg_q.plane_mask       <= cfg_data_i[LevelW-1:0];
        CFG_WIN_FIRST:  cfg_q.window_first_row <= cfg_data_i[RowW-1:0];
        CFG_WIN_LAST:   cfg_q.window_last_row  <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.advance  = !(out_valid_o && out_stall_i);
    ctrl.s1_valid = s1_valid;
  end

  assign in_stall_o = !ctrl.advance;

  gbp_level_rom u_rom (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (ctrl.advance),
    .in_valid_i    (in_valid_i),
    .pixel_value_i (pixel_value_i),
    .s1_valid_o    (s1_valid),
    .level_o       (level)
  );

  gbp_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .ctrl_i        (ctrl),
    .level_i       (level),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .packed_word_o (packed_word_o),
    .frame_end_o   (frame_end_o)
  );

endmodule

`default_nettype wire

>>> verif/greyscale_bitplane_packer_core_tb.sv
// Self-checking testbench for greyscale_bitplane_packer_core: random pixel streams
// with random idling on both sides, checked word by word against a local predictor.
// Depends on gbp_pkg and the packer RTL.
`timescale 1ns / 100ps

module greyscale_bitplane_packer_core_tb;
  import gbp_pkg::*;

  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic [WordW-1:0] packed_word;
    logic             frame_end;
  } plane_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [WordW-1:0]    packed_word_o;
  logic                frame_end_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic [PixW-1:0] pending_pixels [$];
  plane_word_t     expected_words [$];

  logic [LevelW-1:0] plane_mask;
  logic [RowW-1:0]   first_row;
  logic [RowW-1:0]   last_row;
  logic [ColW-1:0]   next_col;
  logic [RowW-1:0]   next_row;
  logic [WordW-1:0]  plane_bits;

  int   send_idle_pct;
  int   recv_idle_pct;
  logic sender_hold;
  logic recv_hold;
  int   fail_count;
  int   cycle_count;

  greyscale_bitplane_packer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packed_word_o (packed_word_o),
    .frame_end_o   (frame_end_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [LevelW-1:0] gamma_level(input logic [PixW-1:0] pix);
    for (int k = 0; k < Levels - 1; k++) begin
      if (pix <= LEVEL_TABLE[k]) return LevelW'(k);
    end
    return LevelW'(Levels - 1);
  endfunction

  task automatic predict_transfer(input logic [PixW-1:0] pix);
    logic        in_window;
    logic        plane_bit;
    plane_word_t w;
    in_window = (next_row >= first_row) && (next_row <= last_row);
    plane_bit = in_window && ((gamma_level(pix) & plane_mask) != '0);
    plane_bits = {plane_bits[WordW-2:0], plane_bit};
    if (next_col[GroupW-1:0] == '1) begin
      w.packed_word = plane_bits;
      w.frame_end = (int'(next_row) >= FRAME_LINES - 1) &&
                    (int'(next_col) + WordW >= LINE_PIXELS);
      expected_words.push_back(w);
    end
    if (int'(next_col) >= LINE_PIXELS - 1) begin
      next_col = '0;
      plane_bits = '0;
      next_row = (int'(next_row) >= FRAME_LINES - 1) ? '0 : next_row + 1'b1;
    end else begin
      next_col = next_col + 1'b1;
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_transfer(pixel_value_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_pixels.size() != 0 && !sender_hold &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i    <= 1'b1;
          pixel_value_i <= pending_pixels.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    plane_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          note_failure($sformatf("unexpected word %h end %b", packed_word_o, frame_end_o));
        end else begin
          want = expected_words.pop_front();
          if (packed_word_o !== want.packed_word || frame_end_o !== want.frame_end)
            note_failure($sformatf("mismatch: expected word %h end %b, got word %h end %b",
                                   want.packed_word, want.frame_end,
                                   packed_word_o, frame_end_o));
        end
      end
      out_stall_i <= recv_hold || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PLANE_MASK: plane_mask = value[LevelW-1:0];
      CFG_WIN_FIRST:  first_row = value[RowW-1:0];
      CFG_WIN_LAST:   last_row = value[RowW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [LevelW-1:0] mask, input logic [RowW-1:0] first,
                            input logic [RowW-1:0] last);
    write_reg(CFG_PLANE_MASK, CfgDataW'(mask));
    write_reg(CFG_WIN_FIRST, CfgDataW'(first));
    write_reg(CFG_WIN_LAST, CfgDataW'(last));
  endtask

  function automatic logic [PixW-1:0] pick_pixel();
    int k;
    k = $urandom_range(0, Levels - 1);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return LEVEL_TABLE[k];
      3:       return LEVEL_TABLE[k] + 1'b1;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic stream_pixels(input int count, input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (count) pending_pixels.push_back(pick_pixel());
  endtask

  // hold until every transfer is through and the pipeline has settled
  task automatic wait_idle();
    do begin
      while (pending_pixels.size() != 0 || in_valid_i || expected_words.size() != 0)
        @(posedge clk_i);
      repeat (8) @(posedge clk_i);
    end while (pending_pixels.size() != 0 || in_valid_i || out_valid_o ||
               expected_words.size() != 0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    pixel_value_i = '0;
    out_stall_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PLANE_MASK;
    cfg_data_i    = '0;
    sender_hold   = 1'b0;
    recv_hold     = 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 63;
    fail_count    = 0;
    cycle_count   = 0;
    plane_mask    = LevelW'(64);
    first_row     = '0;
    last_row      = LastRow;
    next_col      = '0;
    next_row      = '0;
    plane_bits    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, level boundaries, one pixel per level bit and random pixels, under reset settings
    pending_pixels = '{8'd0, 8'd255, 8'd254, 8'd253, 8'd1, 8'd4, 8'd5, 8'd127, 8'd128};
    for (int b = 0; b < LevelW; b++) begin
      pending_pixels.push_back(LEVEL_TABLE[(1 << b) - 1]);
      pending_pixels.push_back(LEVEL_TABLE[(1 << b) - 1] + 1'b1);
    end
    stream_pixels(9, 25, 63);
    wait_idle();

    set_window(LevelW'(127), '0, '1);
    stream_pixels(320, 25, 63);
    wait_idle();

    set_window(LevelW'(1), RowW'(next_row + 1), RowW'(next_row + 3));
    stream_pixels(320, 63, 25);
    fork
      begin
        recv_hold <= 1'b1;
        repeat (400) @(posedge clk_i);
        recv_hold <= 1'b0;
      end
    join_none
    wait_idle();

    set_window('0, '0, '1);
    stream_pixels(192, 63, 25);
    while (pending_pixels.size() > 96) @(posedge clk_i);
    sender_hold <= 1'b1;
    @(posedge clk_i);
    while (in_valid_i || expected_words.size() != 0) @(posedge clk_i);
    sender_hold <= 1'b0;
    wait_idle();

    set_window(LevelW'($urandom_range(1, 127)), '1, '0);
    stream_pixels(192, 63, 25);
    wait_idle();

    set_window(LevelW'($urandom_range(1, 127)), RowW'(next_row + 1), RowW'(next_row + 1));
    stream_pixels(224, 0, 0);
    wait_idle();

    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
